>>> rtl/bmts_pkg.sv
package bmts_pkg;

    localparam int N_W      = 11;  // matrix size / block size registers
    localparam int IDX_W    = 12;  // row, column, depth and tile indexes (start + tile < 2n)
    localparam int OFF_W    = 24;  // element offsets, up to 2n*n
    localparam int ITER_W   = 16;
    localparam int ABASE_W  = 40;
    localparam int ADDR_W   = 41;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 64;
    localparam int SDATA_W  = 8;
    localparam int MDATA_W  = 48;

    localparam int MAX_N_DEF      = 1024;
    localparam int ELEM_BYTES_DEF = 8;

    localparam int PAGE_BYTES    = 4096;
    localparam int COMPUTE_UNITS = 3;
    localparam int SETTLE_CYCLES = 5;  // depth of the derived-config pipeline
    localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

    localparam logic [N_W-1:0]     RST_MATRIX_SIZE = N_W'(64);
    localparam logic [N_W-1:0]     RST_BLOCK_SIZE  = '0;
    localparam logic [ITER_W-1:0]  RST_ITER_COUNT  = ITER_W'(1);
    localparam logic [ABASE_W-1:0] RST_ARRAY_BASE  = '0;

    typedef enum logic [1:0] {
        EV_READ    = 2'd0,
        EV_WRITE   = 2'd1,
        EV_COMPUTE = 2'd2,
        EV_NONE    = 2'd3
    } ev_kind_t;

    typedef enum logic [2:0] {
        PH_READ_C,
        PH_READ_A,
        PH_READ_B,
        PH_COMPUTE,
        PH_WRITE_C
    } phase_t;

    typedef enum logic [1:0] {
        REG_MATRIX_SIZE = 2'd0,
        REG_BLOCK_SIZE  = 2'd1,
        REG_ITER_COUNT  = 2'd2,
        REG_ARRAY_BASE  = 2'd3
    } reg_idx_t;

    // Settled configuration, as sampled by a restart beat.
    typedef struct packed {
        logic              ready;
        logic [N_W-1:0]    n;
        logic [N_W-1:0]    tile_len;
        logic [OFF_W-1:0]  tile_n;     // tile_len * n
        logic [ITER_W-1:0] iters;
        logic [ADDR_W-1:0] a_base;
        logic [ADDR_W-1:0] b_base;
        logic [ADDR_W-1:0] c_base;
    } cfg_t;

    // One event between the sequencer and the address stage.
    typedef struct packed {
        ev_kind_t          kind;
        logic [ADDR_W-1:0] base;
        logic [OFF_W-1:0]  elem;
        logic              last;
    } ev_t;

    function automatic logic [ADDR_W-1:0] align_page(input logic [ADDR_W-1:0] x);
        logic [ADDR_W-1:0] mask;
        mask = ADDR_W'(PAGE_BYTES - 1);
        return (x + mask) & ~mask;
    endfunction

    function automatic logic [IDX_W-1:0] span_end(input logic [IDX_W-1:0] start,
                                                  input logic [N_W-1:0]   len,
                                                  input logic [N_W-1:0]   n);
        logic [IDX_W-1:0] sum;
        sum = start + IDX_W'(len);
        return (sum < IDX_W'(n)) ? sum : IDX_W'(n);
    endfunction

endpackage

>>> rtl/bmts_cfg.sv
module bmts_cfg
    import bmts_pkg::*;
#(
    parameter int MAX_N         = MAX_N_DEF,
    parameter int ELEMENT_BYTES = ELEM_BYTES_DEF
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic [N_W-1:0]     msize_reg;
    logic [N_W-1:0]     bsize_reg;
    logic [ITER_W-1:0]  iters_reg;
    logic [ABASE_W-1:0] abase_reg;
    logic [SETTLE_W-1:0] settle_reg;

    logic [N_W-1:0]     n1_reg, tile1_reg;
    logic [OFF_W-1:0]   nn2_reg, tile_n2_reg;
    logic [ADDR_W-1:0]  bytes3_reg, b4_reg, c5_reg;

    logic [N_W-1:0]     n_clamp;
    logic [N_W-1:0]     tile_sel;
    logic [2*N_W-1:0]   nn_prod, tile_prod;
    logic               wr;
    reg_idx_t           idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[4:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msize_reg  <= RST_MATRIX_SIZE;
            bsize_reg  <= RST_BLOCK_SIZE;
            iters_reg  <= RST_ITER_COUNT;
            abase_reg  <= RST_ARRAY_BASE;
            settle_reg <= SETTLE_W'(SETTLE_CYCLES);
        end
        else
        begin
            if (wr)
            begin
                case (idx)
                    REG_MATRIX_SIZE: msize_reg <= pwdata[N_W-1:0];
                    REG_BLOCK_SIZE:  bsize_reg <= pwdata[N_W-1:0];
                    REG_ITER_COUNT:  iters_reg <= pwdata[ITER_W-1:0];
                    REG_ARRAY_BASE:  abase_reg <= pwdata[ABASE_W-1:0];
                    default:         ;
                endcase
                settle_reg <= SETTLE_W'(SETTLE_CYCLES);
            end
            else if (settle_reg != '0)
            begin
                settle_reg <= settle_reg - SETTLE_W'(1);
            end
        end
    end

    always_comb
    begin
        case (idx)
            REG_MATRIX_SIZE: prdata = PDATA_W'(msize_reg);
            REG_BLOCK_SIZE:  prdata = PDATA_W'(bsize_reg);
            REG_ITER_COUNT:  prdata = PDATA_W'(iters_reg);
            REG_ARRAY_BASE:  prdata = PDATA_W'(abase_reg);
            default:         prdata = '0;
        endcase
    end

    // derived values, one step per stage
    assign n_clamp   = (32'(msize_reg) > 32'(MAX_N)) ? N_W'(MAX_N) : msize_reg;
    assign tile_sel  = (bsize_reg == '0 || bsize_reg >= n1_reg) ? n1_reg : bsize_reg;
    assign nn_prod   = n1_reg * n1_reg;
    assign tile_prod = tile1_reg * n1_reg;

    always_ff @(posedge clk)
    begin
        n1_reg      <= n_clamp;
        tile1_reg   <= tile_sel;
        nn2_reg     <= OFF_W'(nn_prod);
        tile_n2_reg <= OFF_W'(tile_prod);
        bytes3_reg  <= ADDR_W'(nn2_reg) * ADDR_W'(ELEMENT_BYTES);
        b4_reg      <= align_page(ADDR_W'(abase_reg) + bytes3_reg);
        c5_reg      <= align_page(b4_reg + bytes3_reg);
    end

    assign cfg.ready    = (settle_reg == '0);
    assign cfg.n        = n1_reg;
    assign cfg.tile_len = tile1_reg;
    assign cfg.tile_n   = tile_n2_reg;
    assign cfg.iters    = iters_reg;
    assign cfg.a_base   = ADDR_W'(abase_reg);
    assign cfg.b_base   = b4_reg;
    assign cfg.c_base   = c5_reg;

endmodule

>>> rtl/bmts_step.sv
module bmts_step
    import bmts_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic in_valid,
    output logic in_ready,
    input  logic restart,
    input  logic adv,
    output logic ev_valid,
    output ev_t  ev
);

    phase_t             phase_reg, phase_next, e_phase;
    logic               exh_reg, exh_next, e_exh;
    logic [ITER_W-1:0]  iter_reg, iter_next, e_iter;
    logic [IDX_W-1:0]   trs_reg, trs_next, e_trs;
    logic [IDX_W-1:0]   tcs_reg, tcs_next, e_tcs;
    logic [IDX_W-1:0]   tds_reg, tds_next, e_tds;
    logic [IDX_W-1:0]   row_reg, row_next, e_row;
    logic [IDX_W-1:0]   col_reg, col_next, e_col;
    logic [IDX_W-1:0]   dep_reg, dep_next, e_dep;
    logic [IDX_W-1:0]   rend_reg, rend_next, e_rend;
    logic [IDX_W-1:0]   cend_reg, cend_next, e_cend;
    logic [IDX_W-1:0]   dend_reg, dend_next, e_dend;
    logic [OFF_W-1:0]   roff_reg, roff_next, e_roff;      // row * n
    logic [OFF_W-1:0]   doff_reg, doff_next, e_doff;      // depth * n
    logic [OFF_W-1:0]   troff_reg, troff_next, e_troff;   // tile row start * n
    logic [OFF_W-1:0]   tdoff_reg, tdoff_next, e_tdoff;   // tile depth start * n
    logic [N_W-1:0]     n_reg, e_n;
    logic [N_W-1:0]     len_reg, e_len;
    logic [OFF_W-1:0]   tn_reg, e_tn;
    logic [ITER_W-1:0]  iters_reg, e_iters;
    logic [ADDR_W-1:0]  a_reg, e_a, b_reg, e_b, c_reg, e_c;
    logic               s1_valid_reg;
    ev_t                ev_reg, ev_next;

    logic               accept, rs, done;
    logic [IDX_W-1:0]   dep_inc, col_inc, row_inc;
    logic [IDX_W-1:0]   tds_sum, tcs_sum, trs_sum;
    logic [ITER_W:0]    iter_inc;

    assign in_ready = cfg.ready && (!s1_valid_reg || adv);
    assign accept   = in_valid && in_ready;
    assign rs       = restart;

    // restart loads a fresh trace from the settled configuration
    always_comb
    begin
        e_exh   = rs ? (cfg.n == '0 || cfg.iters == '0) : exh_reg;
        e_phase = rs ? PH_READ_C : phase_reg;
        e_iter  = rs ? '0 : iter_reg;
        e_trs   = rs ? '0 : trs_reg;
        e_tcs   = rs ? '0 : tcs_reg;
        e_tds   = rs ? '0 : tds_reg;
        e_row   = rs ? '0 : row_reg;
        e_col   = rs ? '0 : col_reg;
        e_dep   = rs ? '0 : dep_reg;
        e_rend  = rs ? IDX_W'(cfg.tile_len) : rend_reg;
        e_cend  = rs ? IDX_W'(cfg.tile_len) : cend_reg;
        e_dend  = rs ? IDX_W'(cfg.tile_len) : dend_reg;
        e_roff  = rs ? '0 : roff_reg;
        e_doff  = rs ? '0 : doff_reg;
        e_troff = rs ? '0 : troff_reg;
        e_tdoff = rs ? '0 : tdoff_reg;
        e_n     = rs ? cfg.n : n_reg;
        e_len   = rs ? cfg.tile_len : len_reg;
        e_tn    = rs ? cfg.tile_n : tn_reg;
        e_iters = rs ? cfg.iters : iters_reg;
        e_a     = rs ? cfg.a_base : a_reg;
        e_b     = rs ? cfg.b_base : b_reg;
        e_c     = rs ? cfg.c_base : c_reg;
    end

    assign dep_inc  = e_dep + IDX_W'(1);
    assign col_inc  = e_col + IDX_W'(1);
    assign row_inc  = e_row + IDX_W'(1);
    assign tds_sum  = e_tds + IDX_W'(e_len);
    assign tcs_sum  = e_tcs + IDX_W'(e_len);
    assign trs_sum  = e_trs + IDX_W'(e_len);
    assign iter_inc = {1'b0, e_iter} + (ITER_W+1)'(1);

    // next state
    always_comb
    begin
        phase_next = e_phase;
        exh_next   = e_exh;
        iter_next  = e_iter;
        trs_next   = e_trs;
        tcs_next   = e_tcs;
        tds_next   = e_tds;
        row_next   = e_row;
        col_next   = e_col;
        dep_next   = e_dep;
        rend_next  = e_rend;
        cend_next  = e_cend;
        dend_next  = e_dend;
        roff_next  = e_roff;
        doff_next  = e_doff;
        troff_next = e_troff;
        tdoff_next = e_tdoff;
        done       = 1'b0;
        if (!e_exh)
        begin
            case (e_phase)
                PH_READ_C:
                begin
                    dep_next   = e_tds;
                    doff_next  = e_tdoff;
                    phase_next = (e_tds < e_dend) ? PH_READ_A : PH_WRITE_C;
                end
                PH_READ_A:
                begin
                    phase_next = PH_READ_B;
                end
                PH_READ_B:
                begin
                    phase_next = PH_COMPUTE;
                end
                PH_COMPUTE:
                begin
                    dep_next   = dep_inc;
                    doff_next  = e_doff + OFF_W'(e_n);
                    phase_next = (dep_inc < e_dend) ? PH_READ_A : PH_WRITE_C;
                end
                default:
                begin
                    phase_next = PH_READ_C;
                    if (col_inc < e_cend)
                    begin
                        col_next = col_inc;
                    end
                    else if (row_inc < e_rend)
                    begin
                        col_next  = e_tcs;
                        row_next  = row_inc;
                        roff_next = e_roff + OFF_W'(e_n);
                    end
                    else
                    begin
                        // tile finished: depth tile, then column tile, then row tile
                        if (tds_sum < IDX_W'(e_n))
                        begin
                            tds_next   = tds_sum;
                            tdoff_next = e_tdoff + e_tn;
                            dend_next  = span_end(tds_sum, e_len, e_n);
                        end
                        else
                        begin
                            tds_next   = '0;
                            tdoff_next = '0;
                            dend_next  = IDX_W'(e_len);
                            if (tcs_sum < IDX_W'(e_n))
                            begin
                                tcs_next  = tcs_sum;
                                cend_next = span_end(tcs_sum, e_len, e_n);
                            end
                            else
                            begin
                                tcs_next  = '0;
                                cend_next = IDX_W'(e_len);
                                if (trs_sum < IDX_W'(e_n))
                                begin
                                    trs_next   = trs_sum;
                                    troff_next = e_troff + e_tn;
                                    rend_next  = span_end(trs_sum, e_len, e_n);
                                end
                                else
                                begin
                                    trs_next   = '0;
                                    troff_next = '0;
                                    rend_next  = IDX_W'(e_len);
                                    iter_next  = iter_inc[ITER_W-1:0];
                                    done       = (iter_inc >= {1'b0, e_iters});
                                end
                            end
                        end
                        row_next  = trs_next;
                        col_next  = tcs_next;
                        roff_next = troff_next;
                    end
                    if (done)
                    begin
                        exh_next = 1'b1;
                    end
                end
            endcase
        end
    end

    // event for this beat
    always_comb
    begin
        ev_next.kind = EV_NONE;
        ev_next.base = '0;
        ev_next.elem = '0;
        ev_next.last = 1'b0;
        if (!e_exh)
        begin
            case (e_phase)
                PH_READ_C:
                begin
                    ev_next.kind = EV_READ;
                    ev_next.base = e_c;
                    ev_next.elem = e_roff + OFF_W'(e_col);
                end
                PH_READ_A:
                begin
                    ev_next.kind = EV_READ;
                    ev_next.base = e_a;
                    ev_next.elem = e_roff + OFF_W'(e_dep);
                end
                PH_READ_B:
                begin
                    ev_next.kind = EV_READ;
                    ev_next.base = e_b;
                    ev_next.elem = e_doff + OFF_W'(e_col);
                end
                PH_COMPUTE:
                begin
                    ev_next.kind = EV_COMPUTE;
                end
                default:
                begin
                    ev_next.kind = EV_WRITE;
                    ev_next.base = e_c;
                    ev_next.elem = e_roff + OFF_W'(e_col);
                    ev_next.last = done;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            phase_reg    <= PH_READ_C;
            exh_reg      <= 1'b1;
            iter_reg     <= '0;
            trs_reg      <= '0;
            tcs_reg      <= '0;
            tds_reg      <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            dep_reg      <= '0;
            rend_reg     <= '0;
            cend_reg     <= '0;
            dend_reg     <= '0;
            roff_reg     <= '0;
            doff_reg     <= '0;
            troff_reg    <= '0;
            tdoff_reg    <= '0;
            n_reg        <= '0;
            len_reg      <= '0;
            tn_reg       <= '0;
            iters_reg    <= '0;
            a_reg        <= '0;
            b_reg        <= '0;
            c_reg        <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                phase_reg    <= phase_next;
                exh_reg      <= exh_next;
                iter_reg     <= iter_next;
                trs_reg      <= trs_next;
                tcs_reg      <= tcs_next;
                tds_reg      <= tds_next;
                row_reg      <= row_next;
                col_reg      <= col_next;
                dep_reg      <= dep_next;
                rend_reg     <= rend_next;
                cend_reg     <= cend_next;
                dend_reg     <= dend_next;
                roff_reg     <= roff_next;
                doff_reg     <= doff_next;
                troff_reg    <= troff_next;
                tdoff_reg    <= tdoff_next;
                n_reg        <= e_n;
                len_reg      <= e_len;
                tn_reg       <= e_tn;
                iters_reg    <= e_iters;
                a_reg        <= e_a;
                b_reg        <= e_b;
                c_reg        <= e_c;
            end
            else if (adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ev_reg <= ev_next;
        end
    end

    assign ev_valid = s1_valid_reg;
    assign ev       = ev_reg;

endmodule

>>> rtl/bmts_addr.sv
module bmts_addr
    import bmts_pkg::*;
#(
    parameter int ELEMENT_BYTES = ELEM_BYTES_DEF
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               ev_valid,
    input  ev_t                ev,
    output logic               adv,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [MDATA_W-1:0] m_tdata,    // [40:0] address, [42:41] compute_units
    output logic [1:0]         m_tuser,    // [1:0] event_kind
    output logic               m_tlast
);

    logic              valid_reg;
    ev_kind_t          kind_reg;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [1:0]        units_reg, units_next;
    logic              last_reg;

    assign adv        = !valid_reg || m_tready;
    assign addr_next  = ev.base + ADDR_W'(ev.elem) * ADDR_W'(ELEMENT_BYTES);
    assign units_next = (ev.kind == EV_COMPUTE) ? 2'(COMPUTE_UNITS) : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= ev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && ev_valid)
        begin
            kind_reg  <= ev.kind;
            addr_reg  <= addr_next;
            units_reg <= units_next;
            last_reg  <= ev.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(MDATA_W-ADDR_W-2){1'b0}}, units_reg, addr_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

>>> rtl/blocked_matmul_trace_sequencer_core.sv
// Channel   Dir  Beat contents
// --------  ---  ----------------------------------------------------------
// APB       in   register writes/reads: matrix_size, block_size,
//                iteration_count, array_base at byte addresses 0, 8, 16, 24
// s_*       in   one request: restart in tdata[0]
// m_*       out  one trace event: address, compute_units, kind, last
//
// One request beat per cycle, one event beat per cycle, while m_tready is high
// and the configuration has settled. Each event passes the sequencer register,
// then the address register; address = base + offset times ELEMENT_BYTES is
// formed in the second stage. After reset, and after every register write,
// s_tready is low until the settle counter expires, while the derived sizes
// and page-aligned B/C bases settle. A stalled m_tready holds the output beat,
// and s_tready stays high only until the sequencer register is filled.
module blocked_matmul_trace_sequencer_core
    import bmts_pkg::*;
#(
    parameter int MAX_N         = MAX_N_DEF,
    parameter int ELEMENT_BYTES = ELEM_BYTES_DEF
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [SDATA_W-1:0] s_tdata,    // [0] restart
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [MDATA_W-1:0] m_tdata,    // [40:0] address, [42:41] compute_units
    output logic [1:0]         m_tuser,    // [1:0] event_kind
    output logic               m_tlast
);

    cfg_t cfg;
    ev_t  ev;
    logic ev_valid;
    logic adv;

    // register file plus the pipeline that turns sizes into bases
    bmts_cfg #(
        .MAX_N         (MAX_N),
        .ELEMENT_BYTES (ELEMENT_BYTES)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // loop-nest counters; one event decided per accepted request
    bmts_step u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .restart  (s_tdata[0]),
        .adv      (adv),
        .ev_valid (ev_valid),
        .ev       (ev)
    );

    // byte address and output register
    bmts_addr #(
        .ELEMENT_BYTES (ELEMENT_BYTES)
    ) u_addr (
        .clk      (clk),
        .rst_n    (rst_n),
        .ev_valid (ev_valid),
        .ev       (ev),
        .adv      (adv),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
